@@ hw/rtl/fixed_point_exp_neg_core_assert.svh @@
// Assertion macros used by the port-level checker.
`ifndef FIXED_POINT_EXP_NEG_CORE_ASSERT_SVH
`define FIXED_POINT_EXP_NEG_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FPE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, disabled during reset.
`define FPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ hw/rtl/fpexp_pkg.sv @@
// ----------------------------------------------------------------------------
// fpexp_pkg
// Constants for the fixed-point exp(-x) core: ln2 steps, reciprocal,
// fixed polynomial coefficients and register indexes.
// ----------------------------------------------------------------------------
package fpexp_pkg;

  localparam int unsigned HORNER_STEPS = 10;

  localparam logic [63:0] LN2_Q60      = 64'd799144290325165979;
  localparam logic [63:0] HALF_LN2_Q60 = 64'd399572145162582990;
  localparam logic [62:0] NINE_LN2_Q60 = 63'd7192298612926493811;
  localparam logic [63:0] INV_LN2      = 64'd13306513097844322492;
  localparam logic [63:0] SQRT2_Q63    = 64'd13043817825332782212;
  localparam logic [63:0] ONE_Q63      = 64'h8000000000000000;
  localparam logic [63:0] SAT_Q62      = 64'h7FFFFFFFFFFFFFFF;

  localparam logic [63:0] K9 = 64'd30246879334790;
  localparam logic [63:0] K8 = 64'd225090733290635;
  localparam logic [63:0] K7 = 64'd1831549596915338;
  localparam logic [63:0] K4 = 64'd6004799419128215 << 6;
  localparam logic [63:0] K3 = 64'd6004799504283434 << 8;
  localparam logic [63:0] K1 = 64'd4503599627370536 << 11;

  localparam logic [62:0] COEF_SECOND_RST = 63'd4611686018427387904;
  localparam logic [62:0] COEF_FIFTH_RST  = 63'd76861433640456465;
  localparam logic [62:0] COEF_SIXTH_RST  = 63'd12810238940076078;

  typedef enum logic [1:0] {
    REG_COEF_SECOND = 2'd0,
    REG_COEF_FIFTH  = 2'd1,
    REG_COEF_SIXTH  = 2'd2
  } reg_idx_t;

endpackage

@@ hw/rtl/fpexp_mulh.sv @@
// ----------------------------------------------------------------------------
// fpexp_mulh
// Two-stage 64x64 high-half multiply with addend: four 32x32 partial
// products, then the high-word sum plus addend. Side data rides along.
// ----------------------------------------------------------------------------
module fpexp_mulh #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  logic [63:0]       a,
  input  logic [63:0]       b,
  input  logic [63:0]       add_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [63:0]       p_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [63:0]       ll_r, lh_r, hl_r, hh_r, add_r;
  logic [SIDE_W-1:0] side1_r;
  logic              vld1_r;
  logic [33:0]       mid;
  logic [63:0]       p_nxt;

  // Stage one: partial products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r    <= a[31:0]  * b[31:0];
      lh_r    <= a[31:0]  * b[63:32];
      hl_r    <= a[63:32] * b[31:0];
      hh_r    <= a[63:32] * b[63:32];
      add_r   <= add_i;
      side1_r <= side_i;
    end
  end

  // Stage two: collect the high word
  always_comb begin
    mid   = {2'b0, ll_r[63:32]} + {2'b0, lh_r[31:0]} + {2'b0, hl_r[31:0]};
    p_nxt = hh_r + {32'b0, lh_r[63:32]} + {32'b0, hl_r[63:32]}
          + {62'b0, mid[33:32]} + add_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_o    <= p_nxt;
      side_o <= side1_r;
    end
  end

endmodule

@@ hw/rtl/fixed_point_exp_neg_core.sv @@
// Throughput: one item per cycle; the whole pipeline advances together and
// holds while the output register waits on out_ready.
// Each of the twelve 64x64 high multiplies takes two stages.
// Reset clears all valid bits and loads the Taylor coefficient defaults.
// ----------------------------------------------------------------------------
// fixed_point_exp_neg_core
// exp(-x) for x in Q60, result in Q63: ln2 range reduction, degree-9 Horner
// polynomial, sqrt(2) half-step scaling, saturation and final shift.
// ----------------------------------------------------------------------------
module fixed_point_exp_neg_core import fpexp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [62:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [62:0] in_exponent_arg,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_exp_value
);

  localparam int unsigned HSIDE_W = 64 + 64 + 5;

  logic        en;
  logic [62:0] coef_second_r, coef_fifth_r, coef_sixth_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_second_r <= COEF_SECOND_RST;
      coef_fifth_r  <= COEF_FIFTH_RST;
      coef_sixth_r  <= COEF_SIXTH_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_COEF_SECOND: coef_second_r <= cfg_wdata;
        REG_COEF_FIFTH:  coef_fifth_r  <= cfg_wdata;
        REG_COEF_SIXTH:  coef_sixth_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance all stages unless the result is stalled
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage: clamp and reflect
  logic        s0_vld_r;
  logic [63:0] s0_u_r;
  logic [62:0] x_clamp;

  assign x_clamp = (in_exponent_arg > NINE_LN2_Q60) ? NINE_LN2_Q60 : in_exponent_arg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_u_r <= {1'b0, NINE_LN2_Q60 - x_clamp};
    end
  end

  // Whole ln2 steps: estimate
  logic        m1_vld;
  logic [63:0] m1_p, m1_u;

  fpexp_mulh #(.SIDE_W(64)) u_mul_nh (
    .clk, .rst_n, .en,
    .vld_i(s0_vld_r), .a(s0_u_r), .b(INV_LN2), .add_i(64'd0), .side_i(s0_u_r),
    .vld_o(m1_vld), .p_o(m1_p), .side_o(m1_u)
  );

  // Whole steps: remainder and low correction
  logic        s3_vld_r;
  logic [4:0]  s3_nh_r;
  logic [63:0] s3_r_r;
  logic [4:0]  nh_raw;
  logic [63:0] r_a;

  always_comb begin
    nh_raw = m1_p[63:59];
    r_a    = m1_u - 64'(LN2_Q60 * nh_raw);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_nh_r <= nh_raw - {4'b0, r_a[63]};
      s3_r_r  <= r_a[63] ? r_a + LN2_Q60 : r_a;
    end
  end

  // Whole steps: high correction
  logic        s4_vld_r;
  logic [4:0]  s4_nh_r;
  logic [63:0] s4_r_r;
  logic [63:0] r_b;

  assign r_b = s3_r_r - LN2_Q60;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_nh_r <= s3_nh_r + {4'b0, !r_b[63]};
      s4_r_r  <= r_b[63] ? s3_r_r : r_b;
    end
  end

  // Half step: estimate
  logic        m5_vld;
  logic [63:0] m5_p, m5_r;
  logic [4:0]  m5_nh;

  fpexp_mulh #(.SIDE_W(69)) u_mul_rh (
    .clk, .rst_n, .en,
    .vld_i(s4_vld_r), .a(s4_r_r), .b(INV_LN2), .add_i(64'd0),
    .side_i({s4_nh_r, s4_r_r}),
    .vld_o(m5_vld), .p_o(m5_p), .side_o({m5_nh, m5_r})
  );

  // Half step: remainder
  logic        s6_vld_r;
  logic [5:0]  s6_rh_r;
  logic [63:0] s6_rl_r;
  logic [4:0]  s6_nh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else if (en) begin
      s6_vld_r <= m5_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_rh_r <= m5_p[63:58];
      s6_rl_r <= m5_r - 64'(HALF_LN2_Q60 * m5_p[63:58]);
      s6_nh_r <= m5_nh;
    end
  end

  // Half step: correction, scale select, polynomial argument
  logic        s7_vld_r;
  logic [63:0] s7_t_r, s7_scale_r;
  logic [4:0]  s7_nh_r;
  logic [63:0] rl_d, rl_fix;
  logic [6:0]  rh_fix;
  logic [63:0] scale_sel;

  always_comb begin
    rl_d   = s6_rl_r - HALF_LN2_Q60;
    rh_fix = {1'b0, s6_rh_r} + {6'b0, !rl_d[63]};
    rl_fix = rl_d[63] ? s6_rl_r : rl_d;
    if (rh_fix == 7'd0) begin
      scale_sel = ONE_Q63;
    end else if (rh_fix == 7'd1) begin
      scale_sel = SQRT2_Q63;
    end else begin
      scale_sel = 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_vld_r <= 1'b0;
    end else if (en) begin
      s7_vld_r <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_t_r     <= {rl_fix[59:0], 4'b0};
      s7_scale_r <= scale_sel;
      s7_nh_r    <= s6_nh_r;
    end
  end

  // Horner chain, one two-stage multiply per coefficient
  logic [63:0]        acc    [HORNER_STEPS];
  logic               hvld   [HORNER_STEPS];
  logic [HSIDE_W-1:0] hside  [HORNER_STEPS];
  logic [63:0]        addend [HORNER_STEPS];

  always_comb begin
    addend[0] = K8;
    addend[1] = K7;
    addend[2] = {1'b0, coef_sixth_r};
    addend[3] = {1'b0, coef_fifth_r};
    addend[4] = K4;
    addend[5] = K3;
    addend[6] = {1'b0, coef_second_r};
    addend[7] = K1;
    addend[8] = ONE_Q63;
    addend[9] = 64'd0;
  end

  assign acc[0]   = K9;
  assign hvld[0]  = s7_vld_r;
  assign hside[0] = {s7_t_r, s7_scale_r, s7_nh_r};

  for (genvar i = 0; i < HORNER_STEPS - 1; i++) begin : g_horner
    fpexp_mulh #(.SIDE_W(HSIDE_W)) u_mul (
      .clk, .rst_n, .en,
      .vld_i(hvld[i]), .a(acc[i]), .b(hside[i][HSIDE_W-1 -: 64]),
      .add_i(addend[i]), .side_i(hside[i]),
      .vld_o(hvld[i+1]), .p_o(acc[i+1]), .side_o(hside[i+1])
    );
  end

  // Half-step scaling
  logic        ms_vld;
  logic [63:0] ms_p;
  logic [4:0]  ms_nh;

  fpexp_mulh #(.SIDE_W(5)) u_mul_scale (
    .clk, .rst_n, .en,
    .vld_i(hvld[HORNER_STEPS-1]), .a(acc[HORNER_STEPS-1]),
    .b(hside[HORNER_STEPS-1][68:5]), .add_i(addend[HORNER_STEPS-1]),
    .side_i(hside[HORNER_STEPS-1][4:0]),
    .vld_o(ms_vld), .p_o(ms_p), .side_o(ms_nh)
  );

  // Saturate and shift into the output register
  logic [63:0] v_sat;
  logic [6:0]  shamt;
  logic [63:0] out_nxt;

  always_comb begin
    v_sat   = ms_p[63] ? SAT_Q62 : ms_p;
    shamt   = 7'd9 - {{2{ms_nh[4]}}, ms_nh};
    out_nxt = shamt[6] ? 64'd0 : ({v_sat[62:0], 1'b0} >> shamt[5:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ms_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_exp_value <= out_nxt;
    end
  end

endmodule

@@ hw/rtl/fpexp_checker.sv @@
// ----------------------------------------------------------------------------
// fpexp_checker
// Port-level checks for the exp(-x) core, bound to the top level.
// ----------------------------------------------------------------------------
`include "fixed_point_exp_neg_core_assert.svh"

module fpexp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_exp_value
);

  // A stalled result holds its value
  `FPE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_exp_value))

  // Input side is open whenever the output is not blocked
  `FPE_ASSERT_IMP(a_in_open, clk, rst_n, !out_valid || out_ready, in_ready)

  // Input side closes only while a result is stalled
  `FPE_ASSERT_IMP(a_in_closed, clk, rst_n, !in_ready, out_valid && !out_ready)

  // A refused input stays offered
  `FPE_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid)

endmodule

bind fixed_point_exp_neg_core fpexp_checker u_fpexp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_exp_value (out_exp_value)
);

@@ bench/exp_neg_checker.sv @@
// ----------------------------------------------------------------------------
// exp_neg_checker
// Watches the input and result channels of the exp(-x) core, computes the
// expected exp(-x) value of every accepted argument and compares results.
// ----------------------------------------------------------------------------
module exp_neg_checker import fpexp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [62:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [62:0] in_exponent_arg,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_exp_value,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);

  logic [63:0] coef2_q, coef5_q, coef6_q;
  logic [63:0] expected_exp_q[$];

  // High half of the full 128-bit product
  function automatic logic [63:0] prod_hi(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[127:64];
  endfunction

  function automatic logic [63:0] exp_neg_of(input logic [62:0] arg);
    logic [63:0] x, u, nh, r, rh, rl, t, acc, scale, v, shift, res, d;
    x = {1'b0, arg};
    if (x > {1'b0, NINE_LN2_Q60}) x = {1'b0, NINE_LN2_Q60};
    u = {1'b0, NINE_LN2_Q60} - x;
    // whole ln2 steps with correction both ways
    nh = prod_hi(u, INV_LN2) >> 59;
    r = u - nh * LN2_Q60;
    if (r[63]) begin
      nh = nh - 1;
      r = r + LN2_Q60;
    end
    d = r - LN2_Q60;
    if (!d[63]) begin
      nh = nh + 1;
      r = d;
    end
    // half step
    rh = prod_hi(r, INV_LN2) >> 58;
    rl = r - rh * HALF_LN2_Q60;
    d = rl - HALF_LN2_Q60;
    if (!d[63]) begin
      rh = rh + 1;
      rl = d;
    end
    t = rl << 4;
    acc = K9;
    acc = prod_hi(acc, t) + K8;
    acc = prod_hi(acc, t) + K7;
    acc = prod_hi(acc, t) + coef6_q;
    acc = prod_hi(acc, t) + coef5_q;
    acc = prod_hi(acc, t) + K4;
    acc = prod_hi(acc, t) + K3;
    acc = prod_hi(acc, t) + coef2_q;
    acc = prod_hi(acc, t) + K1;
    acc = prod_hi(acc, t) + ONE_Q63;
    scale = (rh == 0) ? ONE_Q63 : ((rh == 1) ? SQRT2_Q63 : 64'd0);
    v = prod_hi(acc, scale);
    if (v[63]) v = SAT_Q62;
    shift = 64'd9 - nh;
    res = (v << 1) >> shift[5:0];
    if (shift > 63) res = '0;
    return res;
  endfunction

  // Track register writes, queue predictions, compare results
  always @(posedge clk) begin
    logic [63:0] want;
    if (!rst_n) begin
      coef2_q <= {1'b0, COEF_SECOND_RST};
      coef5_q <= {1'b0, COEF_FIFTH_RST};
      coef6_q <= {1'b0, COEF_SIXTH_RST};
      expected_exp_q.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_COEF_SECOND: coef2_q <= {1'b0, cfg_wdata};
          REG_COEF_FIFTH:  coef5_q <= {1'b0, cfg_wdata};
          REG_COEF_SIXTH:  coef6_q <= {1'b0, cfg_wdata};
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_exp_q.push_back(exp_neg_of(in_exponent_arg));
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        if (expected_exp_q.size() == 0) begin
          $error("exp_value: unexpected result %h", out_exp_value);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_exp_q.pop_front();
          if (want !== out_exp_value) begin
            $error("exp_value: expected %h actual %h", want, out_exp_value);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  assign pending_count = expected_exp_q.size();

endmodule

@@ bench/tb_fixed_point_exp_neg_core.sv @@
// ----------------------------------------------------------------------------
// tb_fixed_point_exp_neg_core
// Drives arguments and coefficient settings into the exp(-x) core under
// random source and sink idling; a separate checker predicts every result.
// ----------------------------------------------------------------------------
module tb_fixed_point_exp_neg_core;
  import fpexp_pkg::*;

  localparam int LATENCY = 29;

  logic        clk, rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [62:0] cfg_wdata;
  logic        in_valid, in_ready;
  logic [62:0] in_exponent_arg;
  logic        out_valid, out_ready;
  logic [63:0] out_exp_value;
  int          fail_count, pending_count, result_count;
  int          src_idle_pct, sink_idle_pct, sink_hold_cycles, item_count;

  fixed_point_exp_neg_core u_dut (.*);

  exp_neg_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("fixed_point_exp_neg_core test failed");
    $finish;
  end

  // Sink: random stall, or a long hold-off when requested
  initial begin
    out_ready = 1'b0;
    sink_hold_cycles = 0;
    forever begin
      @(negedge clk);
      if (sink_hold_cycles > 0) begin
        out_ready <= 1'b0;
        sink_hold_cycles = sink_hold_cycles - 1;
      end else begin
        out_ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  task automatic write_coef(input reg_idx_t idx, input logic [62:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Present one argument and hold it until the transfer
  task automatic send_arg(input logic [62:0] arg);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_exponent_arg <= arg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    item_count++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected result has come
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic logic [62:0] rand_arg();
    logic [62:0] a;
    a = 63'({$urandom(), $urandom()});
    case ($urandom_range(5))
      0: return a;
      1: return a % (NINE_LN2_Q60 + 63'd1);
      2: return NINE_LN2_Q60 - 63'($urandom_range(4));
      3: return 63'((64'($urandom_range(9)) * LN2_Q60) + 64'($urandom_range(3)) - 64'd1);
      4: return 63'((64'($urandom_range(18)) * HALF_LN2_Q60) ^ 64'($urandom_range(1)));
      default: return a % 63'd800000000000000000;
    endcase
  endfunction

  task automatic run_random(input int n, input int sidle, input int kidle);
    src_idle_pct = sidle;
    sink_idle_pct = kidle;
    repeat (n) send_arg(rand_arg());
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_COEF_SECOND;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_exponent_arg = '0;
    src_idle_pct = 0;
    sink_idle_pct = 0;
    item_count = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes, clamp, ln2 and half-step edges
    send_arg('0);
    send_arg(63'd1);
    send_arg(NINE_LN2_Q60);
    send_arg(NINE_LN2_Q60 - 63'd1);
    send_arg(NINE_LN2_Q60 + 63'd1);
    send_arg('1);
    send_arg(63'h2AAA_AAAA_AAAA_AAAA);
    send_arg(63'h5555_5555_5555_5555);
    for (int k = 1; k <= 8; k++) send_arg(63'(64'(k) * LN2_Q60));
    for (int k = 1; k <= 5; k++) send_arg(63'(64'(2 * k - 1) * HALF_LN2_Q60));
    drain_results();

    // Defaults, sender light and sink heavy idling
    run_random(170, 13, 71);
    drain_results();

    // Coefficients written close to the defaults, roles swapped
    write_coef(REG_COEF_SECOND, 63'd4611686018427387904);
    write_coef(REG_COEF_FIFTH, 63'd76861433640456465);
    write_coef(REG_COEF_SIXTH, 63'd12810238940076079);
    run_random(170, 71, 13);
    drain_results();

    // Extremes: all ones forces saturation, then all zeros
    write_coef(REG_COEF_SECOND, '1);
    write_coef(REG_COEF_FIFTH, '1);
    write_coef(REG_COEF_SIXTH, '1);
    sink_hold_cycles = 150;
    run_random(100, 0, 0);
    drain_results();
    write_coef(REG_COEF_SECOND, '0);
    write_coef(REG_COEF_FIFTH, '0);
    write_coef(REG_COEF_SIXTH, '0);
    run_random(60, 0, 0);
    drain_results();

    // Random coefficients, no idling
    write_coef(REG_COEF_SECOND, 63'({$urandom(), $urandom()}));
    write_coef(REG_COEF_FIFTH, 63'({$urandom(), $urandom()}));
    write_coef(REG_COEF_SIXTH, 63'({$urandom(), $urandom()}));
    run_random(150, 0, 0);
    drain_results();

    $display("Sent %0d arguments, checked %0d results over five coefficient settings,",
             item_count, result_count);
    $display("including clamped arguments, saturation and a long sink stall.");
    if (fail_count == 0) begin
      $display("fixed_point_exp_neg_core test passed");
    end else begin
      $display("fixed_point_exp_neg_core test failed");
    end
    $finish;
  end

endmodule
